// File: hdl/qvr_pkg.sv
// Types, constants and the arctangent table for the quaternion vector rotator.
`default_nettype none
package qvr_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int WORD_W       = 32;

  // angle wrap: restoring reduction of (angle + 2^31) by the 360 degree period
  localparam longint PERIOD      = longint'(360) << FRAC_BITS;
  localparam longint HALF_PERIOD = longint'(180) << FRAC_BITS;
  localparam longint WRAP_OFS    = (longint'(1) << 31) % PERIOD;
  localparam int     QUO_W       = 25 - FRAC_BITS;
  localparam int     SH_W        = $clog2(QUO_W + 1);
  localparam int     REM_W       = 34;
  localparam int     RED_W       = FRAC_BITS + 10;

  localparam int     ANG_PROD_W  = RED_W + 26;
  localparam longint DEG2RAD_Q30 = 18740330;

  // CORDIC datapath, 30 fraction bits
  localparam int     CW          = 34;
  localparam longint GAIN_Q30    = 652032874;
  localparam int     IDX_W       = $clog2(CORDIC_STEPS);

  // quaternion sandwich widths
  localparam int UW    = 34;
  localparam int WW    = FRAC_BITS + 3;
  localparam int TPW   = 66;
  localparam int TW    = TPW + 2 - FRAC_BITS;
  localparam int LO_W  = 26;
  localparam int HI_W  = TW - LO_W;
  localparam int PL_W  = LO_W + 1 + UW;
  localparam int PH_W  = HI_W + UW;
  localparam int FPW   = TW + UW;
  localparam int SUM_W = FPW + 2;
  localparam int RES_W = SUM_W - FRAC_BITS;

  typedef struct packed {
    logic signed [WORD_W-1:0] vec_x;
    logic signed [WORD_W-1:0] vec_y;
    logic signed [WORD_W-1:0] vec_z;
    logic signed [WORD_W-1:0] axis_x;
    logic signed [WORD_W-1:0] axis_y;
    logic signed [WORD_W-1:0] axis_z;
    logic signed [WORD_W-1:0] angle_deg;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] rot_x;
    logic signed [WORD_W-1:0] rot_y;
    logic signed [WORD_W-1:0] rot_z;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] vec_x;
    logic signed [WORD_W-1:0] vec_y;
    logic signed [WORD_W-1:0] vec_z;
    logic signed [WORD_W-1:0] axis_x;
    logic signed [WORD_W-1:0] axis_y;
    logic signed [WORD_W-1:0] axis_z;
  } side_t;

  typedef struct packed {
    logic             valid;
    side_t            side;
    logic [REM_W-1:0] rem;
  } wrap_t;

  typedef struct packed {
    logic                 valid;
    side_t                side;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cor_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'h3243F6A8;
      5'd1:  a = 32'h1DAC6705;
      5'd2:  a = 32'h0FADBAFC;
      5'd3:  a = 32'h07F56EA6;
      5'd4:  a = 32'h03FEAB76;
      5'd5:  a = 32'h01FFD55B;
      5'd6:  a = 32'h00FFFAAA;
      5'd7:  a = 32'h007FFF55;
      5'd8:  a = 32'h003FFFEA;
      5'd9:  a = 32'h001FFFFD;
      5'd10: a = 32'h000FFFFF;
      5'd11: a = 32'h0007FFFF;
      5'd12: a = 32'h0003FFFF;
      5'd13: a = 32'h0001FFFF;
      5'd14: a = 32'h0000FFFF;
      5'd15: a = 32'h00007FFF;
      5'd16: a = 32'h00003FFF;
      5'd17: a = 32'h00001FFF;
      5'd18: a = 32'h00000FFF;
      5'd19: a = 32'h000007FF;
      5'd20: a = 32'h000003FF;
      5'd21: a = 32'h000001FF;
      5'd22: a = 32'h000000FF;
      5'd23: a = 32'h0000007F;
      5'd24: a = 32'h0000003F;
      5'd25: a = 32'h0000001F;
      5'd26: a = 32'h0000000F;
      5'd27: a = 32'h00000008;
      5'd28: a = 32'h00000004;
      5'd29: a = 32'h00000002;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return $signed({{(CW-32){1'b0}}, a});
  endfunction

endpackage
`default_nettype wire

// File: hdl/qvr_wrap_cell.sv
// One restoring step of the angle reduction: subtract the shifted period if it fits.
`default_nettype none
module qvr_wrap_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic [qvr_pkg::SH_W-1:0] shift,
  input  wire qvr_pkg::wrap_t     d_i,
  output qvr_pkg::wrap_t          d_o
);
  import qvr_pkg::*;

  wrap_t            d_r, d_nxt;
  logic [REM_W-1:0] div;

  always_comb begin
    div   = REM_W'(PERIOD) << shift;
    d_nxt = d_i;
    if (d_i.rem >= div) begin
      d_nxt.rem = d_i.rem - div;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;
endmodule
`default_nettype wire

// File: hdl/qvr_cordic_cell.sv
// One rotation-mode CORDIC iteration.
`default_nettype none
module qvr_cordic_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic [qvr_pkg::IDX_W-1:0] idx,
  input  wire qvr_pkg::cor_t             d_i,
  output qvr_pkg::cor_t                  d_o
);
  import qvr_pkg::*;

  cor_t                 d_r, d_nxt;
  logic signed [CW-1:0] dx, dy, at;

  always_comb begin
    dx    = d_i.y >>> idx;
    dy    = d_i.x >>> idx;
    at    = atan_q30(5'(idx));
    d_nxt = d_i;
    if (!d_i.z[CW-1]) begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - at;
    end else begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;
endmodule
`default_nettype wire

// File: hdl/qvr_sandwich.sv
// Quaternion build and q*(v,0)*conj(q) product pipeline with saturation.
`default_nettype none
module qvr_sandwich (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire qvr_pkg::cor_t c_i,
  output qvr_pkg::res_t      r_o
);
  import qvr_pkg::*;

  localparam int NST = 7;
  localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(2147483647);
  localparam logic signed [RES_W-1:0] SAT_MIN = ~SAT_MAX;

  logic [NST-1:0] vld_r;

  // stage 1: axis * sin products, w rounding
  logic signed [TPW-1:0]    pa1_r [3];
  logic signed [WW-1:0]     w1_r;
  logic signed [WORD_W-1:0] v1_r [3];
  // stage 2: quaternion parts
  logic signed [UW-1:0]     u2_r [3];
  logic signed [WW-1:0]     w2_r;
  logic signed [WORD_W-1:0] v2_r [3];
  // stage 3: q*v products (w*v, u_a*v_b, u_b*v_a, u_j*v_j)
  logic signed [TPW-1:0]    pw3_r [3];
  logic signed [TPW-1:0]    pab3_r [3];
  logic signed [TPW-1:0]    pba3_r [3];
  logic signed [TPW-1:0]    pd3_r [3];
  logic signed [UW-1:0]     u3_r [3];
  logic signed [WW-1:0]     w3_r;
  // stage 4: t = q*v, index 3 holds the scalar part
  logic signed [TW-1:0]     t4_r [4];
  logic signed [UW-1:0]     u4_r [3];
  logic signed [WW-1:0]     w4_r;
  // stage 5/6: split and recombined products with conj(q)
  logic signed [PL_W-1:0]   pl5_r [12];
  logic signed [PH_W-1:0]   ph5_r [12];
  logic signed [FPW-1:0]    fp6_r [12];
  out_item_t                out_r;

  logic signed [CW-1:0]     wrnd;
  logic signed [TPW-1:0]    sa [3];
  logic signed [TPW+1:0]    ts [4];
  logic signed [UW-1:0]     qop [12];
  logic signed [TW-1:0]     top [12];
  logic signed [HI_W-1:0]   thi;
  logic signed [SUM_W-1:0]  rs [3];
  logic signed [RES_W-1:0]  rr [3];
  logic signed [WORD_W-1:0] rsat [3];
  logic                     sat;
  int                       a, b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], c_i.valid};
    end
  end

  always_comb begin
    wrnd  = (c_i.x + (CW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    sa[0] = TPW'(c_i.side.axis_x) * TPW'(c_i.y);
    sa[1] = TPW'(c_i.side.axis_y) * TPW'(c_i.y);
    sa[2] = TPW'(c_i.side.axis_z) * TPW'(c_i.y);

    for (int j = 0; j < 3; j++) begin
      a = (j == 2) ? 0 : j + 1;
      b = (j == 0) ? 2 : j - 1;
      ts[j] = (TPW+2)'(pw3_r[j]) + (TPW+2)'(pab3_r[j]) - (TPW+2)'(pba3_r[j]);
      // operand pairs of r_j: (-t_w,u_j) (t_j,w) (t_b,u_a) (-t_a,u_b)
      top[4*j]   = t4_r[3];
      qop[4*j]   = u4_r[j];
      top[4*j+1] = t4_r[j];
      qop[4*j+1] = UW'(w4_r);
      top[4*j+2] = t4_r[b];
      qop[4*j+2] = u4_r[a];
      top[4*j+3] = t4_r[a];
      qop[4*j+3] = u4_r[b];
    end
    ts[3] = -((TPW+2)'(pd3_r[0]) + (TPW+2)'(pd3_r[1]) + (TPW+2)'(pd3_r[2]));

    sat = 1'b0;
    for (int j = 0; j < 3; j++) begin
      rs[j] = -SUM_W'(fp6_r[4*j]) + SUM_W'(fp6_r[4*j+1])
              + SUM_W'(fp6_r[4*j+2]) - SUM_W'(fp6_r[4*j+3]);
      rr[j] = RES_W'(rs[j] >>> FRAC_BITS);
      if (rr[j] > SAT_MAX) begin
        rsat[j] = WORD_W'(SAT_MAX);
        sat     = 1'b1;
      end else if (rr[j] < SAT_MIN) begin
        rsat[j] = WORD_W'(SAT_MIN);
        sat     = 1'b1;
      end else begin
        rsat[j] = WORD_W'(rr[j]);
      end
    end
    thi = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      for (int j = 0; j < 3; j++) begin
        pa1_r[j] <= sa[j];
      end
      w1_r    <= WW'(wrnd);
      v1_r[0] <= c_i.side.vec_x;
      v1_r[1] <= c_i.side.vec_y;
      v1_r[2] <= c_i.side.vec_z;
      // stage 2
      for (int j = 0; j < 3; j++) begin
        u2_r[j] <= UW'((pa1_r[j] + (TPW'(1) <<< 29)) >>> 30);
        v2_r[j] <= v1_r[j];
      end
      w2_r <= w1_r;
      // stage 3
      for (int j = 0; j < 3; j++) begin
        pw3_r[j]  <= TPW'(w2_r) * TPW'(v2_r[j]);
        pab3_r[j] <= TPW'(u2_r[(j == 2) ? 0 : j + 1]) * TPW'(v2_r[(j == 0) ? 2 : j - 1]);
        pba3_r[j] <= TPW'(u2_r[(j == 0) ? 2 : j - 1]) * TPW'(v2_r[(j == 2) ? 0 : j + 1]);
        pd3_r[j]  <= TPW'(u2_r[j]) * TPW'(v2_r[j]);
        u3_r[j]   <= u2_r[j];
      end
      w3_r <= w2_r;
      // stage 4
      for (int j = 0; j < 4; j++) begin
        t4_r[j] <= TW'(ts[j] >>> FRAC_BITS);
      end
      for (int j = 0; j < 3; j++) begin
        u4_r[j] <= u3_r[j];
      end
      w4_r <= w3_r;
      // stage 5: wide t times q, cut into low and high partial products
      for (int k = 0; k < 12; k++) begin
        pl5_r[k] <= PL_W'($signed({1'b0, top[k][LO_W-1:0]})) * PL_W'(qop[k]);
        ph5_r[k] <= PH_W'($signed(top[k][TW-1:LO_W]) + thi) * PH_W'(qop[k]);
      end
      // stage 6
      for (int k = 0; k < 12; k++) begin
        fp6_r[k] <= (FPW'(ph5_r[k]) <<< LO_W) + FPW'(pl5_r[k]);
      end
      // stage 7: output register
      out_r.rot_x     <= rsat[0];
      out_r.rot_y     <= rsat[1];
      out_r.rot_z     <= rsat[2];
      out_r.saturated <= sat;
    end
  end

  assign r_o.valid = vld_r[NST-1];
  assign r_o.item  = out_r;
endmodule
`default_nettype wire

// File: hdl/quaternion_vector_rotate_core.sv
// Top level: angle wrap chain, half-angle scaling, CORDIC chain and product pipeline.
//
//   port group | dir | payload      | handshake
//   in_*       | in  | in_item_t    | in_valid / in_ready
//   out_*      | out | out_item_t   | out_valid / out_ready
//
// One request per cycle unless the output stalls. The pipeline is 25-FRAC_BITS wrap
// cells, 2 angle stages, CORDIC_STEPS cells and 7 product stages.
// The whole pipeline advances together; it holds while the output register is
// full and out_ready is low, and in_ready follows that same enable.
// Reset clears the wrap, angle and CORDIC stages and the product stage valid bits.
`default_nettype none
module quaternion_vector_rotate_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire qvr_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output qvr_pkg::out_item_t      out_data
);
  import qvr_pkg::*;

  logic  en;
  wrap_t wc [QUO_W+1];
  cor_t  cc [CORDIC_STEPS+1];
  res_t  res;

  typedef struct packed {
    logic                    valid;
    side_t                   side;
    logic signed [RED_W-1:0] red;
  } ang_t;

  typedef struct packed {
    logic                         valid;
    side_t                        side;
    logic signed [ANG_PROD_W-1:0] prod;
  } rad_t;

  ang_t             sa_r, sa_nxt;
  rad_t             sb_r, sb_nxt;
  logic [REM_W-1:0] red0;
  side_t            in_side;

  assign en       = !res.valid || out_ready;
  assign in_ready = en;

  assign in_side.vec_x  = in_data.vec_x;
  assign in_side.vec_y  = in_data.vec_y;
  assign in_side.vec_z  = in_data.vec_z;
  assign in_side.axis_x = in_data.axis_x;
  assign in_side.axis_y = in_data.axis_y;
  assign in_side.axis_z = in_data.axis_z;

  // offset by 2^31 so the reduction works on an unsigned value
  assign wc[0].valid = in_valid;
  assign wc[0].side  = in_side;
  assign wc[0].rem   = {2'b00, in_data.angle_deg ^ 32'h8000_0000};

  for (genvar k = 0; k < QUO_W; k++) begin : g_wrap
    qvr_wrap_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .shift (SH_W'(QUO_W - 1 - k)),
      .d_i   (wc[k]),
      .d_o   (wc[k+1])
    );
  end

  // remove the 2^31 offset, then fold into [-180, 180)
  always_comb begin
    if (wc[QUO_W].rem < REM_W'(WRAP_OFS)) begin
      red0 = wc[QUO_W].rem + REM_W'(PERIOD - WRAP_OFS);
    end else begin
      red0 = wc[QUO_W].rem - REM_W'(WRAP_OFS);
    end
    sa_nxt.valid = wc[QUO_W].valid;
    sa_nxt.side  = wc[QUO_W].side;
    if (red0 >= REM_W'(HALF_PERIOD)) begin
      sa_nxt.red = RED_W'(red0) - RED_W'(PERIOD);
    end else begin
      sa_nxt.red = RED_W'(red0);
    end
    sb_nxt.valid = sa_r.valid;
    sb_nxt.side  = sa_r.side;
    sb_nxt.prod  = ANG_PROD_W'(sa_r.red) * ANG_PROD_W'(DEG2RAD_Q30);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_r <= '0;
      sb_r <= '0;
    end else if (en) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
    end
  end

  assign cc[0].valid = sb_r.valid;
  assign cc[0].side  = sb_r.side;
  assign cc[0].x     = CW'(GAIN_Q30);
  assign cc[0].y     = '0;
  assign cc[0].z     = CW'((sb_r.prod + (ANG_PROD_W'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1));

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    qvr_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .idx   (IDX_W'(i)),
      .d_i   (cc[i]),
      .d_o   (cc[i+1])
    );
  end

  qvr_sandwich u_sandwich (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .c_i   (cc[CORDIC_STEPS]),
    .r_o   (res)
  );

  assign out_valid = res.valid;
  assign out_data  = res.item;
endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the quaternion vector rotation core.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qvr_pkg::*;

  localparam int  FRAC    = 16;
  localparam int  STEPS   = 16;
  localparam int  TAIL    = 60;
  localparam real FAIL_NS = 5_000_000.0;

  localparam longint ANGLE_PERIOD = longint'(360) << FRAC;
  localparam longint ANGLE_HALF   = longint'(180) << FRAC;
  localparam longint RAD_PER_DEG  = 18740330;
  localparam longint CORDIC_K     = 652032874;
  localparam longint ONE          = longint'(1) << FRAC;

  localparam longint ARCTAN_Q30 [STEPS] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  in_item_t  pending_reqs[$];
  out_item_t expected_rots[$];
  int        mismatches;
  int        burst_left;
  int        gap_left;
  int        ready_cnt;
  int        ready_mode;

  quaternion_vector_rotate_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // exact sum of four products, floored by 2^FRAC
  function automatic logic signed [127:0] quad_sum(
    longint a1, longint b1, longint a2, longint b2,
    longint a3, longint b3, longint a4, longint b4);
    logic signed [127:0] w1, w2, w3, w4, v1, v2, v3, v4;
    w1 = a1; w2 = a2; w3 = a3; w4 = a4;
    v1 = b1; v2 = b2; v3 = b3; v4 = b4;
    return (w1 * v1 + w2 * v2 + w3 * v3 + w4 * v4) >>> FRAC;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v, ref logic sat);
    if (v > 128'sh7FFFFFFF) begin
      sat = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (v < -128'sh80000000) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic out_item_t rotate_vector(in_item_t req);
    longint vx, vy, vz, ax, ay, az, red, x, y, z, dx, dy;
    longint ux, uy, uz, w, tx, ty, tz, tw;
    logic signed [127:0] acc;
    logic sat;
    out_item_t res;
    vx = req.vec_x;  vy = req.vec_y;  vz = req.vec_z;
    ax = req.axis_x; ay = req.axis_y; az = req.axis_z;
    red = longint'(req.angle_deg) % ANGLE_PERIOD;
    if (red < 0) red += ANGLE_PERIOD;
    if (red >= ANGLE_HALF) red -= ANGLE_PERIOD;
    z = (red * RAD_PER_DEG + (longint'(1) << FRAC)) >>> (FRAC + 1);
    x = CORDIC_K;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN_Q30[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN_Q30[i];
      end
    end
    ux = (ax * y + (longint'(1) << 29)) >>> 30;
    uy = (ay * y + (longint'(1) << 29)) >>> 30;
    uz = (az * y + (longint'(1) << 29)) >>> 30;
    w  = (x + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
    acc = quad_sum(w, vx, uy, vz, -uz, vy, 0, 0);  tx = acc[63:0];
    acc = quad_sum(w, vy, uz, vx, -ux, vz, 0, 0);  ty = acc[63:0];
    acc = quad_sum(w, vz, ux, vy, -uy, vx, 0, 0);  tz = acc[63:0];
    acc = quad_sum(-ux, vx, -uy, vy, -uz, vz, 0, 0); tw = acc[63:0];
    sat = 1'b0;
    res.rot_x = clamp32(quad_sum(-tw, ux, w, tx, uy, tz, -uz, ty), sat);
    res.rot_y = clamp32(quad_sum(-tw, uy, w, ty, uz, tx, -ux, tz), sat);
    res.rot_z = clamp32(quad_sum(-tw, uz, w, tz, ux, ty, -uy, tx), sat);
    res.saturated = sat;
    return res;
  endfunction

  task automatic add_req(longint vx, longint vy, longint vz, longint ax, longint ay,
                         longint az, longint ang);
    in_item_t r;
    r.vec_x = vx[31:0];  r.vec_y = vy[31:0];  r.vec_z = vz[31:0];
    r.axis_x = ax[31:0]; r.axis_y = ay[31:0]; r.axis_z = az[31:0];
    r.angle_deg = ang[31:0];
    pending_reqs.push_back(r);
  endtask

  function automatic longint rand_span(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender: bursts of requests separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_rots.push_back(rotate_vector(in_data));
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stretches of always-ready, always-stalled and random ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_cnt  <= 0;
      ready_mode <= 0;
      mismatches <= 0;
    end else begin
      if (ready_cnt == 0) begin
        ready_cnt  <= $urandom_range(1, 30);
        ready_mode <= $urandom_range(0, 3);
      end else begin
        ready_cnt <= ready_cnt - 1;
      end
      out_ready <= (ready_mode == 0) ? 1'b1 : (ready_mode == 1) ? 1'b0 : 1'($urandom);
      if (out_valid && out_ready) begin
        if (expected_rots.size() == 0) begin
          $error("unexpected result rot_x=%h", out_data.rot_x);
          mismatches <= mismatches + 1;
        end else begin
          out_item_t exp_rot;
          exp_rot = expected_rots.pop_front();
          if (out_data.rot_x !== exp_rot.rot_x)
            $error("rot_x expected %h actual %h", exp_rot.rot_x, out_data.rot_x);
          if (out_data.rot_y !== exp_rot.rot_y)
            $error("rot_y expected %h actual %h", exp_rot.rot_y, out_data.rot_y);
          if (out_data.rot_z !== exp_rot.rot_z)
            $error("rot_z expected %h actual %h", exp_rot.rot_z, out_data.rot_z);
          if (out_data.saturated !== exp_rot.saturated)
            $error("saturated expected %b actual %b", exp_rot.saturated,
                   out_data.saturated);
          if (out_data !== exp_rot)
            mismatches <= mismatches + 1;
        end
      end
    end
  end

  initial begin
    #(FAIL_NS);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    longint mx, mn;
    mx = 64'sh7FFFFFFF;
    mn = -64'sh80000000;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    // directed: zero angle, quarter turns, half-turn edge, wrap, extremes
    add_req(0, 0, 0, 0, 0, 0, 0);
    add_req(ONE, 0, 0, 0, 0, ONE, 0);
    add_req(ONE, 0, 0, 0, 0, ONE, 90 * ONE);
    add_req(ONE, 2 * ONE, 3 * ONE, 0, 0, ONE, -90 * ONE);
    add_req(ONE, 2 * ONE, 3 * ONE, ONE, 0, 0, 180 * ONE);
    add_req(ONE, 2 * ONE, 3 * ONE, ONE, 0, 0, -180 * ONE);
    add_req(ONE, 2 * ONE, 3 * ONE, 0, ONE, 0, 360 * ONE);
    add_req(ONE, 2 * ONE, 3 * ONE, 0, ONE, 0, 450 * ONE);
    add_req(ONE, 2 * ONE, 3 * ONE, 0, ONE, 0, -270 * ONE);
    add_req(5 * ONE, -ONE, 7, 0, ONE, 0, mx);
    add_req(5 * ONE, -ONE, 7, 0, ONE, 0, mn);
    add_req(mx, mx, mx, 0, 0, ONE, 45 * ONE);
    add_req(mn, mn, mn, 0, 0, ONE, 45 * ONE);
    add_req(mx, mn, mx, ONE, ONE, ONE, 120 * ONE);
    add_req(ONE, ONE, ONE, mx, mx, mx, 90 * ONE);
    add_req(ONE, ONE, ONE, mn, mn, mn, 90 * ONE);
    add_req(mx, mx, mx, mx, mn, mx, 179 * ONE);
    add_req(mn, mx, mn, mn, mx, mn, mn);
    add_req(-1, -1, -1, -1, -1, -1, -1);
    add_req(3 * ONE, 0, 0, 2 * ONE, 0, 0, 90 * ONE);
    add_req(ONE, ONE, 0, 0, 0, 2 * ONE, 60 * ONE);
    add_req(123456, -654321, 99999, 37837, 37837, 37837, 12345678);
    repeat (700) begin
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 4)
        // unit axis along a signed coordinate direction
        case ($urandom_range(0, 2))
          0: add_req(rand_span(1000 * ONE), rand_span(1000 * ONE), rand_span(1000 * ONE),
                     $urandom_range(0, 1) ? ONE : -ONE, 0, 0, rand_span(720 * ONE));
          1: add_req(rand_span(1000 * ONE), rand_span(1000 * ONE), rand_span(1000 * ONE),
                     0, $urandom_range(0, 1) ? ONE : -ONE, 0, rand_span(720 * ONE));
          default: add_req(rand_span(1000 * ONE), rand_span(1000 * ONE),
                           rand_span(1000 * ONE), 0, 0,
                           $urandom_range(0, 1) ? ONE : -ONE, rand_span(720 * ONE));
        endcase
      else if (kind < 7)
        add_req(rand_span(30000 * ONE), rand_span(30000 * ONE), rand_span(30000 * ONE),
                rand_span(37837), rand_span(37837), rand_span(37837),
                rand_span(32000 * ONE));
      else
        add_req(longint'(int'($urandom)), longint'(int'($urandom)),
                longint'(int'($urandom)), longint'(int'($urandom)),
                longint'(int'($urandom)), longint'(int'($urandom)),
                longint'(int'($urandom)));
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_rots.size() == 0);
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && expected_rots.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
hdl/qvr_pkg.sv
hdl/qvr_wrap_cell.sv
hdl/qvr_cordic_cell.sv
hdl/qvr_sandwich.sv
hdl/quaternion_vector_rotate_core.sv
verif/tb.sv
